[design/fddt_pkg.sv]
// ----------------------------------------------------------------------------
// fddt_pkg: shared definitions for the frame difference block
// Field widths, register indexes and default sizes used by all modules.
// ----------------------------------------------------------------------------
package fddt_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int SQ_W        = 2 * CHAN_W;
   localparam int DIST_W      = 18;
   localparam int LIMIT_W     = 18;
   localparam int DIM_W       = 10;
   localparam int OFFSET_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int RSP_DATA_W  = 8;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_MAX_OFFSET = 4;

   localparam logic [DIM_W-1:0]    RESET_FRAME_WIDTH  = DIM_W'(512);
   localparam logic [DIM_W-1:0]    RESET_FRAME_HEIGHT = DIM_W'(512);
   localparam logic [OFFSET_W-1:0] RESET_FRAME_OFFSET = OFFSET_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_LIMIT    = 3'd0,
      CSR_HIGH_LIMIT   = 3'd1,
      CSR_FRAME_WIDTH  = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_FRAME_OFFSET = 3'd4
   } csr_index_type;

endpackage

[design/fddt_history.sv]
// ----------------------------------------------------------------------------
// fddt_history: pixel history memory
// Single-clock memory, one write and one registered read per cycle.
// A read and a write to the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module fddt_history #(
   parameter int ADDR_W = 20
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [fddt_pkg::PIX_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [fddt_pkg::PIX_W-1:0] wr_data
);
   import fddt_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fddt_distance.sv]
// ----------------------------------------------------------------------------
// fddt_distance: squared color distance and threshold compare
// Stage one squares the channel differences, stage two sums and compares.
// ----------------------------------------------------------------------------
module fddt_distance (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [fddt_pkg::PIX_W-1:0]   pixel,
   input  logic [fddt_pkg::PIX_W-1:0]   reference,
   input  logic [fddt_pkg::LIMIT_W-1:0] low_limit,
   input  logic [fddt_pkg::LIMIT_W-1:0] high_limit,
   output logic                         low_fg,
   output logic                         high_fg
);
   import fddt_pkg::*;

   logic [SQ_W-1:0]   sq_ff [3];
   logic [SQ_W-1:0]   sq_in [3];
   logic [DIST_W-1:0] sq_sum;
   logic              low_fg_ff;
   logic              high_fg_ff;

   always_comb begin
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] d;
      for (int i = 0; i < 3; i++) begin
         p = pixel[i*CHAN_W +: CHAN_W];
         r = reference[i*CHAN_W +: CHAN_W];
         d = (p > r) ? (p - r) : (r - p);
         sq_in[i] = SQ_W'(d) * SQ_W'(d);
      end
   end

   assign sq_sum = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff      <= sq_in;
         low_fg_ff  <= sq_sum > low_limit;
         high_fg_ff <= sq_sum > high_limit;
      end
   end

   assign low_fg  = low_fg_ff;
   assign high_fg = high_fg_ff;

endmodule

[design/frame_difference_dual_threshold.sv]
// Registered stages: memory read, square, sum/compare. A stalled result moves into a skid
// register; pipeline and input hold only while it is full. Otherwise one pixel per cycle;
// the history memory takes one read and one write each cycle. Reset clears position counters,
// frame count, write slot, registers and valid flags, but not the history memory;
// the user must see it is only read at entries already written; the block does not enforce it.
// ----------------------------------------------------------------------------
// frame_difference_dual_threshold: frame differencing foreground detector
// Compares each RGB pixel with the same position a set number of frames back, or with the
// first frame during warm-up, and flags it against a low and a high squared-distance limit.
// ----------------------------------------------------------------------------
module frame_difference_dual_threshold #(
   parameter int MAX_WIDTH  = fddt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fddt_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_OFFSET = fddt_pkg::DEF_MAX_OFFSET
) (
   input  logic                              clock,
   input  logic                              reset,
   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
   input  logic [fddt_pkg::PIX_W-1:0]        req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // low_foreground [0], high_foreground [1], zero fill [7:2]
   output logic [fddt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fddt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fddt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fddt_pkg::*;

   localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW    = (MAX_OFFSET > 1) ? $clog2(MAX_OFFSET) : 1;
   localparam int FSW   = $clog2(MAX_OFFSET + 1);
   localparam int AW    = SW + RW + CW;
   localparam int WXW   = $clog2(MAX_WIDTH + 1)  > DIM_W ? $clog2(MAX_WIDTH + 1)  : DIM_W;
   localparam int HXW   = $clog2(MAX_HEIGHT + 1) > DIM_W ? $clog2(MAX_HEIGHT + 1) : DIM_W;
   localparam int XW    = (WXW > HXW ? WXW : HXW) + 1;
   localparam int OXW   = (FSW > OFFSET_W ? FSW : OFFSET_W) + 2;

   // configuration registers
   logic [LIMIT_W-1:0]  low_limit_ff;
   logic [LIMIT_W-1:0]  high_limit_ff;
   logic [DIM_W-1:0]    frame_width_ff;
   logic [DIM_W-1:0]    frame_height_ff;
   logic [OFFSET_W-1:0] frame_offset_ff;

   // position and frame state
   logic [CW-1:0]  col_ff,  col_in;
   logic [RW-1:0]  row_ff,  row_in;
   logic [FSW-1:0] seen_ff, seen_in;
   logic [SW-1:0]  ws_ff,   ws_in;

   // pipeline
   logic             s1_valid_ff, s1_use_ff, s1_eof_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s2_valid_ff, s2_eof_ff;
   logic             rsp_valid_ff, rsp_eof_ff;
   logic             skid_valid_ff, skid_valid_in;
   logic             skid_low_ff, skid_high_ff, skid_eof_ff;

   logic             advance;
   logic             accept;
   logic [XW-1:0]    w_x, h_x, col_x, row_x;
   logic [OXW-1:0]   off_x, ws_x, seen_x, rs_x;
   logic [CW-1:0]    col;
   logic [RW-1:0]    row;
   logic [SW-1:0]    rs;
   logic             eol, eof, use_ref;
   logic [PIX_W-1:0] ref_data;
   logic [PIX_W-1:0] ref_sel;
   logic             low_fg, high_fg;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign csr_ready  = 1'b1;

   // park the last-stage result when the sink stalls while the pipeline moves
   assign skid_valid_in = skid_valid_ff ? !rsp_tready : (rsp_valid_ff && !rsp_tready);

   // clamp frame size and offset
   always_comb begin
      logic [XW-1:0]  fw, fh;
      logic [OXW-1:0] fo;
      fw  = XW'(frame_width_ff);
      fh  = XW'(frame_height_ff);
      fo  = OXW'(frame_offset_ff);
      w_x = (fw == '0) ? XW'(1) : ((fw > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : fw);
      h_x = (fh == '0) ? XW'(1) : ((fh > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : fh);
      off_x = (fo > OXW'(MAX_OFFSET)) ? OXW'(MAX_OFFSET) : fo;
   end

   // current position, end of row and frame
   always_comb begin
      col_x = (XW'(col_ff) >= w_x) ? (w_x - XW'(1)) : XW'(col_ff);
      row_x = (XW'(row_ff) >= h_x) ? (h_x - XW'(1)) : XW'(row_ff);
      col   = col_x[CW-1:0];
      row   = row_x[RW-1:0];
      eol   = (col_x + XW'(1)) >= w_x;
      eof   = eol && ((row_x + XW'(1)) >= h_x);
   end

   // reference slot: the first frame during warm-up, else offset frames back
   always_comb begin
      ws_x    = OXW'(ws_ff);
      seen_x  = OXW'(seen_ff);
      use_ref = (off_x != '0) && (seen_ff != '0);
      if (seen_x < off_x) begin
         rs_x = '0;
      end else if (ws_x >= off_x) begin
         rs_x = ws_x - off_x;
      end else begin
         rs_x = ws_x + OXW'(MAX_OFFSET) - off_x;
      end
      rs = rs_x[SW-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      seen_in = seen_ff;
      ws_in   = ws_ff;
      if (accept) begin
         if (eol) begin
            col_in = '0;
            if (eof) begin
               row_in = '0;
               if (seen_ff < FSW'(MAX_OFFSET)) begin
                  seen_in = seen_ff + FSW'(1);
               end
               ws_in = (ws_x == OXW'(MAX_OFFSET - 1)) ? '0 : ws_ff + SW'(1);
            end else begin
               row_in = row + RW'(1);
            end
         end else begin
            col_in = col + CW'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff    <= '0;
         high_limit_ff   <= '0;
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         frame_offset_ff <= RESET_FRAME_OFFSET;
         col_ff          <= '0;
         row_ff          <= '0;
         seen_ff         <= '0;
         ws_ff           <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_LIMIT:    low_limit_ff    <= csr_data[LIMIT_W-1:0];
               CSR_HIGH_LIMIT:   high_limit_ff   <= csr_data[LIMIT_W-1:0];
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[DIM_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[DIM_W-1:0];
               CSR_FRAME_OFFSET: frame_offset_ff <= csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
         col_ff        <= col_in;
         row_ff        <= row_in;
         seen_ff       <= seen_in;
         ws_ff         <= ws_in;
         skid_valid_ff <= skid_valid_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff    <= req_tdata;
         s1_use_ff    <= use_ref;
         s1_eof_ff    <= eof;
         s2_eof_ff    <= s1_eof_ff;
         rsp_eof_ff   <= s2_eof_ff;
         skid_low_ff  <= low_fg;
         skid_high_ff <= high_fg;
         skid_eof_ff  <= rsp_eof_ff;
      end
   end

   // read the reference and store the current pixel in the same cycle
   fddt_history #(
      .ADDR_W (AW)
   ) u_history (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr ({rs, row, col}),
      .rd_data (ref_data),
      .wr_en   (accept),
      .wr_addr ({ws_ff, row, col}),
      .wr_data (req_tdata)
   );

   // without a reference compare the pixel with itself: distance zero
   assign ref_sel = s1_use_ff ? ref_data : s1_pix_ff;

   fddt_distance u_distance (
      .clock      (clock),
      .enable     (advance),
      .pixel      (s1_pix_ff),
      .reference  (ref_sel),
      .low_limit  (low_limit_ff),
      .high_limit (high_limit_ff),
      .low_fg     (low_fg),
      .high_fg    (high_fg)
   );

   // the parked result is older than the one held in the last stage
   assign rsp_tvalid = skid_valid_ff || rsp_valid_ff;
   assign rsp_tlast  = skid_valid_ff ? skid_eof_ff : rsp_eof_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2){1'b0}},
                        (skid_valid_ff ? skid_high_ff : high_fg),
                        (skid_valid_ff ? skid_low_ff  : low_fg)};

   // write slot moves only at the end of a frame
   a_slot_hold : assert property (@(posedge clock) disable iff (reset)
      (accept && !eof) |=> (ws_ff == $past(ws_ff)))
      else $error("write slot changed inside a frame");

   a_slot_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && eof && (ws_x == OXW'(MAX_OFFSET - 1))) |=> (ws_ff == '0))
      else $error("write slot did not wrap");

   a_seen_count : assert property (@(posedge clock) disable iff (reset)
      (accept && eof && (seen_ff < FSW'(MAX_OFFSET))) |=> (seen_ff == $past(seen_ff) + FSW'(1)))
      else $error("frame count did not advance at end of frame");

   a_seen_sat : assert property (@(posedge clock) disable iff (reset)
      (seen_ff == FSW'(MAX_OFFSET)) |=> (seen_ff == FSW'(MAX_OFFSET)))
      else $error("frame count left saturation");

endmodule

[test/frame_diff_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_diff_checker: foreground mask predictor and result checker
// Watches the pixel, result and register channels of the frame difference
// block, keeps its own frame history and register copies, predicts the two
// threshold flags and the end-of-frame mark for every accepted pixel, and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_diff_checker #(
   parameter int MAX_WIDTH  = fddt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fddt_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_OFFSET = fddt_pkg::DEF_MAX_OFFSET
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [fddt_pkg::PIX_W-1:0]       req_tdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [fddt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [fddt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fddt_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               pending_count,
   output int                               results_checked,
   output int                               frame_ends,
   output int                               low_fg_count,
   output int                               high_fg_count
);
   import fddt_pkg::*;

   localparam int SLOT_PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int PRINT_CAP   = 100;

   typedef struct packed {
      logic low_fg;
      logic high_fg;
      logic frame_end;
   } mask_type;

   bit [PIX_W-1:0] history [MAX_OFFSET*SLOT_PIXELS];
   mask_type       expected_masks [$];

   logic [LIMIT_W-1:0]  low_limit_r;
   logic [LIMIT_W-1:0]  high_limit_r;
   logic [DIM_W-1:0]    width_r;
   logic [DIM_W-1:0]    height_r;
   logic [OFFSET_W-1:0] offset_r;
   int col_q;
   int row_q;
   int frames_done;
   int slot_wr;

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      results_checked = 0;
      frame_ends      = 0;
      low_fg_count    = 0;
      high_fg_count   = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH at result %0d: %s got %0h expected %0h",
                  results_checked, what, got, wanted);
      mismatch_count++;
   endtask

   function automatic int sq_diff(input logic [CHAN_W-1:0] x, input logic [CHAN_W-1:0] y);
      int d;
      d = int'(x) - int'(y);
      return d * d;
   endfunction

   task automatic predict_mask(input logic [PIX_W-1:0] pix);
      int w;
      int h;
      int off;
      int col;
      int row;
      int pos;
      int ref_slot;
      int sq_sum;
      logic [PIX_W-1:0] ref_pix;
      logic row_end;
      mask_type m;
      w   = (width_r == 0) ? 1 : (int'(width_r) > MAX_WIDTH) ? MAX_WIDTH : int'(width_r);
      h   = (height_r == 0) ? 1 : (int'(height_r) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_r);
      off = (int'(offset_r) > MAX_OFFSET) ? MAX_OFFSET : int'(offset_r);
      // counters past a shrunken frame end the row or frame right away
      col = (col_q >= w) ? w - 1 : col_q;
      row = (row_q >= h) ? h - 1 : row_q;
      pos = row * MAX_WIDTH + col;
      sq_sum = 0;
      if (off != 0 && frames_done != 0) begin
         // during warm-up the first frame stands in as the reference
         ref_slot = (frames_done < off) ? 0 : (slot_wr + MAX_OFFSET - off) % MAX_OFFSET;
         ref_pix  = history[ref_slot*SLOT_PIXELS + pos];
         sq_sum = sq_diff(pix[7:0], ref_pix[7:0]) + sq_diff(pix[15:8], ref_pix[15:8])
                + sq_diff(pix[23:16], ref_pix[23:16]);
      end
      history[slot_wr*SLOT_PIXELS + pos] = pix;
      row_end     = (col + 1 >= w);
      m.frame_end = row_end && (row + 1 >= h);
      m.low_fg    = sq_sum > int'(low_limit_r);
      m.high_fg   = sq_sum > int'(high_limit_r);
      expected_masks.push_back(m);
      if (row_end) begin
         col_q = 0;
         if (m.frame_end) begin
            row_q = 0;
            if (frames_done < MAX_OFFSET) frames_done++;
            slot_wr = (slot_wr + 1) % MAX_OFFSET;
         end else begin
            row_q = row + 1;
         end
      end else begin
         col_q = col + 1;
         row_q = row;
      end
   endtask

   always @(posedge clock) begin
      mask_type wanted;
      if (reset) begin
         low_limit_r  = '0;
         high_limit_r = '0;
         width_r      = RESET_FRAME_WIDTH;
         height_r     = RESET_FRAME_HEIGHT;
         offset_r     = RESET_FRAME_OFFSET;
         col_q        = 0;
         row_q        = 0;
         frames_done  = 0;
         slot_wr      = 0;
         expected_masks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_LIMIT:    low_limit_r  = csr_data[LIMIT_W-1:0];
               CSR_HIGH_LIMIT:   high_limit_r = csr_data[LIMIT_W-1:0];
               CSR_FRAME_WIDTH:  width_r      = csr_data[DIM_W-1:0];
               CSR_FRAME_HEIGHT: height_r     = csr_data[DIM_W-1:0];
               CSR_FRAME_OFFSET: offset_r     = csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
         // check the result before queuing this edge's pixel
         if (rsp_tvalid && rsp_tready) begin
            if (expected_masks.size() == 0) begin
               report_mismatch("result with no pixel pending", 32'(rsp_tdata), '0);
            end else begin
               wanted = expected_masks.pop_front();
               if (rsp_tdata[0] !== wanted.low_fg)
                  report_mismatch("low_foreground", 32'(rsp_tdata[0]), 32'(wanted.low_fg));
               if (rsp_tdata[1] !== wanted.high_fg)
                  report_mismatch("high_foreground", 32'(rsp_tdata[1]), 32'(wanted.high_fg));
               if (rsp_tlast !== wanted.frame_end)
                  report_mismatch("end_of_frame", 32'(rsp_tlast), 32'(wanted.frame_end));
               if (rsp_tdata[RSP_DATA_W-1:2] !== '0)
                  report_mismatch("zero fill", 32'(rsp_tdata[RSP_DATA_W-1:2]), '0);
               low_fg_count  += int'(wanted.low_fg);
               high_fg_count += int'(wanted.high_fg);
               frame_ends    += int'(wanted.frame_end);
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) predict_mask(req_tdata);
      end
      pending_count = expected_masks.size();
   end

endmodule

[test/frame_difference_dual_threshold_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_dual_threshold_tb: top level testbench
// Drives pixel frames of many sizes, offsets and limits into the block with
// bursty input and a stalling result side, reprograms registers between
// phases, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module frame_difference_dual_threshold_tb;
   import fddt_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_DIST    = 3 * 255 * 255;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_BURSTY
   } stall_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [PIX_W-1:0]       req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_LOW_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatch_count;
   int pending_count;
   int results_checked;
   int frame_ends;
   int low_fg_count;
   int high_fg_count;

   int             cycle_count = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_left  = 0;
   int             stall_tick  = 0;
   int             burst_left  = 0;
   bit             sender_gaps = 1'b1;
   int             eff_width   = 1;
   int             eff_height  = 1;

   frame_difference_dual_threshold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frame_diff_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .frame_ends      (frame_ends),
      .low_fg_count    (low_fg_count),
      .high_fg_count   (high_fg_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      stall_tick++;
      case (stall_mode)
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_tready <= ((stall_tick % 7) >= 3);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               if ($urandom_range(0, 31) == 0) stall_left = $urandom_range(5, 20);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [PIX_W-1:0] rgb(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
      return {c, b, a};
   endfunction

   function automatic logic [PIX_W-1:0] make_pixel(input logic [PIX_W-1:0] base);
      logic [PIX_W-1:0] p;
      int k;
      p = base;
      case ($urandom_range(0, 9))
         0, 1: ;
         2, 3, 4: begin
            for (k = 0; k < 3; k++) p[k*8 +: 8] = base[k*8 +: 8] ^ 8'($urandom_range(0, 3));
         end
         5, 6: begin
            for (k = 0; k < 3; k++) p[k*8 +: 8] = base[k*8 +: 8] ^ 8'($urandom_range(0, 31));
         end
         7: p = PIX_W'($urandom);
         8: begin
            for (k = 0; k < 3; k++) p[k*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: p = base ^ (PIX_W'(1) << $urandom_range(0, PIX_W-1));
      endcase
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return CSR_DATA_W'(MAX_DIST);
         2: return CSR_DATA_W'($urandom_range(0, 8));
         3: return CSR_DATA_W'($urandom_range(0, 600));
         4: return CSR_DATA_W'($urandom_range(0, 4000));
         5: return CSR_DATA_W'($urandom_range(0, MAX_DIST));
         default: return '1;
      endcase
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold the sender until every queued pixel has its result
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
         if (!sender_gaps) gap = 0;
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input int count, input logic [PIX_W-1:0] base);
      int i;
      int pause_at;
      pause_at = ($urandom_range(0, 2) == 0) ? count / 2 : -1;
      for (i = 0; i < count; i++) begin
         if (i == pause_at) drain_results();
         send_pixel(make_pixel(base));
      end
   endtask

   // new geometry with a zero offset, so no stale history is compared
   task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_FRAME_OFFSET, '0);
      eff_width  = (w == 0) ? 1 : (int'(w) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w);
      eff_height = (h == 0) ? 1 : (int'(h) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h);
   endtask

   task automatic pick_pacing();
      stall_mode  = stall_mode_type'($urandom_range(0, 3));
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (!sender_gaps) stall_mode = STALL_NONE;
   endtask

   task automatic run_random_phase(input bit resize, input bit unit_frame);
      logic [DIM_W-1:0]    w;
      logic [DIM_W-1:0]    h;
      logic [OFFSET_W-1:0] off;
      logic [PIX_W-1:0]    base;
      base = PIX_W'($urandom);
      drain_results();
      pick_pacing();
      if (resize) begin
         w = unit_frame ? DIM_W'(1) : DIM_W'($urandom_range(0, 6));
         h = unit_frame ? DIM_W'(1) : DIM_W'($urandom_range(0, 4));
         set_geometry(w, h);
         // enough frames to refill every history slot at the new size
         send_run(5 * eff_width * eff_height, base);
         drain_results();
      end
      write_csr(CSR_LOW_LIMIT, pick_limit());
      write_csr(CSR_HIGH_LIMIT, pick_limit());
      off = ($urandom_range(0, 5) == 5) ? OFFSET_W'($urandom_range(5, 7))
                                        : OFFSET_W'($urandom_range(0, 4));
      write_csr(CSR_FRAME_OFFSET, CSR_DATA_W'(off));
      send_run($urandom_range(20, 60), base);
   endtask

   initial begin : stimulus
      int i;
      logic [PIX_W-1:0] base;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x2 frames, offset 3: first frame, then two warm-up frames against it
      set_geometry(DIM_W'(3), DIM_W'(2));
      write_csr(CSR_LOW_LIMIT, CSR_DATA_W'(1));
      write_csr(CSR_HIGH_LIMIT, CSR_DATA_W'(MAX_DIST - 1));
      write_csr(CSR_FRAME_OFFSET, CSR_DATA_W'(3));
      stall_mode = STALL_RANDOM;
      send_pixel(rgb(8'h00, 8'h00, 8'h00));
      send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
      send_pixel(rgb(8'hAA, 8'h55, 8'hAA));
      send_pixel(rgb(8'h01, 8'h01, 8'h01));
      send_pixel(rgb(8'h80, 8'h80, 8'h80));
      send_pixel(rgb(8'h7F, 8'h7F, 8'h7F));
      send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
      send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
      send_pixel(rgb(8'h55, 8'hAA, 8'h55));
      send_pixel(rgb(8'h01, 8'h01, 8'h00));
      send_pixel(rgb(8'h82, 8'h80, 8'h80));
      send_pixel(rgb(8'hFF, 8'h7F, 8'h7F));
      send_pixel(rgb(8'h00, 8'h00, 8'h00));
      send_pixel(rgb(8'h00, 8'h00, 8'h00));
      send_pixel(PIX_W'($urandom));
      send_pixel(rgb(8'h01, 8'h01, 8'h01));
      send_pixel(rgb(8'h80, 8'h80, 8'h80));
      send_pixel(PIX_W'($urandom));

      // same geometry, new offset and limits
      run_random_phase(1'b0, 1'b0);
      for (i = 0; i < 4; i++) run_random_phase((i == 0) || ($urandom_range(0, 1) == 1), i == 0);

      // widest frame: one row, width above range
      drain_results();
      stall_mode  = STALL_BURSTY;
      sender_gaps = 1'b0;
      base = PIX_W'($urandom);
      set_geometry(DIM_W'(1023), DIM_W'(0));
      write_csr(CSR_LOW_LIMIT, pick_limit());
      write_csr(CSR_HIGH_LIMIT, pick_limit());
      send_run(eff_width * eff_height + 24, base);

      drain_results();
      repeat (8) @(negedge clock);
      $display("Checked %0d results over %0d frame ends (1x1 up to 6x4 frames and a 512x1 frame)",
               results_checked, frame_ends);
      $display("Offsets 0 to 7 and limits 0 to full scale; %0d low and %0d high foreground",
               low_fg_count, high_fg_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
design/fddt_pkg.sv
design/fddt_history.sv
design/fddt_distance.sv
design/frame_difference_dual_threshold.sv
test/frame_diff_checker.sv
test/frame_difference_dual_threshold_tb.sv
